### rtl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants for the clock page replacer.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int OWNER_W = 4;
  localparam int PAGE_W  = 12;
  localparam int FRAME_W = 4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_TOUCH = 1'b1;

  typedef struct packed {
    logic               is_touch;
    logic               tf_in_range;
    logic [OWNER_W-1:0] pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] tf;
  } cpr_entry_t;

endpackage

### rtl/cpr_in_if.sv
// ----------------------------------------------------------------------------
// cpr_in_if
// Command channel: valid/ready handshake plus one command beat.
// ----------------------------------------------------------------------------
interface cpr_in_if
  import cpr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               command;
  logic [OWNER_W-1:0] process_id;
  logic [PAGE_W-1:0]  page_number;
  logic [FRAME_W-1:0] touch_frame;

  modport source (output valid, command, process_id, page_number, touch_frame,
                  input ready);
  modport sink   (input valid, command, process_id, page_number, touch_frame,
                  output ready);
endinterface

### rtl/cpr_out_if.sv
// ----------------------------------------------------------------------------
// cpr_out_if
// Result channel: valid/ready handshake plus one result beat.
// ----------------------------------------------------------------------------
interface cpr_out_if
  import cpr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_index;
  logic               page_fault;
  logic [OWNER_W-1:0] evicted_owner;
  logic [PAGE_W-1:0]  evicted_page;

  modport source (output valid, frame_index, page_fault, evicted_owner, evicted_page,
                  input ready);
  modport sink   (input valid, frame_index, page_fault, evicted_owner, evicted_page,
                  output ready);
endinterface

### rtl/cpr_ram.sv
// ----------------------------------------------------------------------------
// cpr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/cpr_front.sv
// ----------------------------------------------------------------------------
// cpr_front
// Accepts command beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module cpr_front
  import cpr_pkg::*;
#(
  parameter int NUM_FRAMES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  cpr_in_if.sink      in_if,
  output logic        q_valid,
  output cpr_entry_t  q_entry,
  input  logic        q_pop
);

  cpr_entry_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  cpr_entry_t new_entry;

  assign in_if.ready = (count_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;

  always_comb begin
    new_entry.is_touch    = (in_if.command == CMD_TOUCH);
    new_entry.tf_in_range = (32'(in_if.touch_frame) < NUM_FRAMES);
    new_entry.pid         = in_if.process_id;
    new_entry.page        = in_if.page_number;
    new_entry.tf          = in_if.touch_frame;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_entry;
    end
  end

  assign q_valid = (count_r != 2'd0);
  assign q_entry = entry_r[rd_ptr_r];

endmodule

### rtl/cpr_back.sv
// ----------------------------------------------------------------------------
// cpr_back
// Executes queued commands: fill count, reference bits, clock hand sweep,
// owner/page RAM and the result register.
// ----------------------------------------------------------------------------
module cpr_back
  import cpr_pkg::*;
#(
  parameter int NUM_FRAMES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cpr_entry_t  q_entry,
  output logic        q_pop,
  cpr_out_if.source   out_if
);

  localparam int FW = $clog2(NUM_FRAMES);
  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam int DW = OWNER_W + PAGE_W;
  localparam logic [FW-1:0] LAST_FRAME = FW'(NUM_FRAMES - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(NUM_FRAMES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [FW-1:0]         hand_r, hand_nxt;
  logic [NUM_FRAMES-1:0] ref_r, ref_nxt;
  logic [OWNER_W-1:0]    pid_r, pid_nxt;
  logic [PAGE_W-1:0]     page_r, page_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0]    out_frame_r, out_frame_nxt;
  logic                  out_fault_r, out_fault_nxt;
  logic [OWNER_W-1:0]    out_owner_r, out_owner_nxt;
  logic [PAGE_W-1:0]     out_page_r, out_page_nxt;

  logic                  out_free;
  logic                  load;
  logic                  ram_we, ram_re;
  logic [FW-1:0]         ram_waddr;
  logic [DW-1:0]         ram_wdata, ram_rdata;
  logic [FW+3:0]         tf_w;
  logic [FW-1:0]         tf_idx;
  logic [FW+3:0]         hand_w;
  logic [FW+3:0]         fill_w;
  logic [FW-1:0]         hand_next;

  assign out_free  = !out_valid_r || out_if.ready;
  assign tf_w      = {{FW{1'b0}}, q_entry.tf};
  assign tf_idx    = tf_w[FW-1:0];
  assign hand_w    = {4'd0, hand_r};
  assign fill_w    = {4'd0, fill_r[FW-1:0]};
  assign hand_next = (hand_r == LAST_FRAME) ? '0 : hand_r + 1'b1;

  cpr_ram #(.WIDTH(DW), .DEPTH(NUM_FRAMES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (hand_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    hand_nxt      = hand_r;
    ref_nxt       = ref_r;
    pid_nxt       = pid_r;
    page_nxt      = page_r;
    q_pop         = 1'b0;
    load          = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = hand_r;
    ram_wdata     = {pid_r, page_r};
    out_frame_nxt = out_frame_r;
    out_fault_nxt = out_fault_r;
    out_owner_nxt = out_owner_r;
    out_page_nxt  = out_page_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_entry.is_touch) begin
            if (q_entry.tf_in_range && (32'(q_entry.tf) < 32'(fill_r))) begin
              ref_nxt[tf_idx] = 1'b1;
            end
            load          = 1'b1;
            out_frame_nxt = q_entry.tf;
            out_fault_nxt = 1'b0;
            out_owner_nxt = '0;
            out_page_nxt  = '0;
          end else if (fill_r != FULL_COUNT) begin
            ram_we                  = 1'b1;
            ram_waddr               = fill_r[FW-1:0];
            ram_wdata               = {q_entry.pid, q_entry.page};
            ref_nxt[fill_r[FW-1:0]] = 1'b1;
            fill_nxt                = fill_r + 1'b1;
            load                    = 1'b1;
            out_frame_nxt           = fill_w[3:0];
            out_fault_nxt           = 1'b0;
            out_owner_nxt           = '0;
            out_page_nxt            = '0;
          end else begin
            pid_nxt   = q_entry.pid;
            page_nxt  = q_entry.page;
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (ref_r[hand_r]) begin
          ref_nxt[hand_r] = 1'b0;
          hand_nxt        = hand_next;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free) begin
          ram_we          = 1'b1;
          ref_nxt[hand_r] = 1'b1;
          hand_nxt        = hand_next;
          load            = 1'b1;
          out_frame_nxt   = hand_w[3:0];
          out_fault_nxt   = 1'b1;
          out_owner_nxt   = ram_rdata[DW-1:PAGE_W];
          out_page_nxt    = ram_rdata[PAGE_W-1:0];
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      hand_r      <= '0;
      ref_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      hand_r      <= hand_nxt;
      ref_r       <= ref_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pid_r       <= pid_nxt;
    page_r      <= page_nxt;
    out_frame_r <= out_frame_nxt;
    out_fault_r <= out_fault_nxt;
    out_owner_r <= out_owner_nxt;
    out_page_r  <= out_page_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.frame_index   = out_frame_r;
  assign out_if.page_fault    = out_fault_r;
  assign out_if.evicted_owner = out_owner_r;
  assign out_if.evicted_page  = out_page_r;

endmodule

### rtl/clock_page_replacer_top.sv
// ----------------------------------------------------------------------------
// clock_page_replacer_top
// Clock (second-chance) page replacement over NUM_FRAMES physical frames.
// ----------------------------------------------------------------------------
// One result beat per command beat, in order. Frames fill lowest-first and
// are never freed, so a fill count tracks the free frames. A touch, or an
// allocate while a frame is still free, is done in the idle state of the
// execution stage. An allocate on a full set takes the command in the idle
// state, walks the clock hand one frame per cycle (one to NUM_FRAMES+1
// frames) in the sweep state and then reads the owner/page RAM in the read
// state, which waits until the result register is free.
// A two-entry command queue and a result register let input and output stall
// independently. No clearing pass is needed after reset.
module clock_page_replacer_top
  import cpr_pkg::*;
#(
  parameter int NUM_FRAMES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  cpr_in_if.sink    in_if,
  cpr_out_if.source out_if
);

  logic       q_valid;
  logic       q_pop;
  cpr_entry_t q_entry;

  cpr_front #(.NUM_FRAMES(NUM_FRAMES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  cpr_back #(.NUM_FRAMES(NUM_FRAMES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for clock_page_replacer_top. A queue of command beats,
// directed first and then random, feeds a clocked driver. At each accepted
// beat a local copy of the clock replacement policy works out the grant,
// which a clocked monitor compares with the result channel. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import cpr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFRAMES     = 16;
  localparam int RANDOM_CMDS = 1100;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic               command;
    logic [OWNER_W-1:0] pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] tf;
    bit                 drain;
  } cmd_beat_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic               page_fault;
    logic [OWNER_W-1:0] evicted_owner;
    logic [PAGE_W-1:0]  evicted_page;
  } grant_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cpr_in_if  in_ch ();
  cpr_out_if out_ch ();

  clock_page_replacer_top #(.NUM_FRAMES(NFRAMES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // frame table mirror
  logic               resident [NFRAMES];
  logic [OWNER_W-1:0] owner_of [NFRAMES];
  logic [PAGE_W-1:0]  page_of  [NFRAMES];
  logic               ref_set  [NFRAMES];
  int                 hand_pos;

  cmd_beat_t cmd_backlog[$];
  grant_t    pending_grants[$];
  cmd_beat_t cur_beat;
  int        errors;
  int        beats_in;
  int        beats_out;
  int        src_gap;
  int        src_mode;
  int        snk_stall;
  int        snk_mode;
  logic      send;

  function automatic int draw_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < (mode == 1 ? 75 : 40)) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void load_frame(int f, logic [OWNER_W-1:0] pid,
                                     logic [PAGE_W-1:0] page);
    resident[f] = 1'b1;
    owner_of[f] = pid;
    page_of[f]  = page;
    ref_set[f]  = 1'b1;
  endfunction

  function automatic grant_t run_clock_policy(cmd_beat_t b);
    grant_t g;
    int     f;
    g = '0;
    if (b.command == CMD_TOUCH) begin
      if (int'(b.tf) < NFRAMES && resident[b.tf]) ref_set[b.tf] = 1'b1;
      g.frame_index = b.tf;
      return g;
    end
    for (f = 0; f < NFRAMES; f++) begin
      if (!resident[f]) begin
        load_frame(f, b.pid, b.page);
        g.frame_index = f[FRAME_W-1:0];
        return g;
      end
    end
    if (hand_pos >= NFRAMES) hand_pos = 0;
    // at most one full lap clearing bits, then a victim
    for (int k = 0; k <= NFRAMES; k++) begin
      f = hand_pos;
      hand_pos = (f + 1 >= NFRAMES) ? 0 : f + 1;
      if (ref_set[f]) begin
        ref_set[f] = 1'b0;
      end else begin
        g.frame_index   = f[FRAME_W-1:0];
        g.page_fault    = 1'b1;
        g.evicted_owner = owner_of[f];
        g.evicted_page  = page_of[f];
        load_frame(f, b.pid, b.page);
        return g;
      end
    end
    return g;
  endfunction

  task automatic push_alloc(logic [OWNER_W-1:0] pid, logic [PAGE_W-1:0] page,
                            bit drain = 1'b0);
    cmd_beat_t b;
    b.command = CMD_ALLOC;
    b.pid     = pid;
    b.page    = page;
    b.tf      = FRAME_W'($urandom_range(0, 15));
    b.drain   = drain;
    cmd_backlog.push_back(b);
  endtask

  task automatic push_touch(logic [FRAME_W-1:0] tf);
    cmd_beat_t b;
    b.command = CMD_TOUCH;
    b.pid     = OWNER_W'($urandom_range(0, 15));
    b.page    = PAGE_W'($urandom_range(0, 4095));
    b.tf      = tf;
    b.drain   = 1'b0;
    cmd_backlog.push_back(b);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp_v,
               act_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      send = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        pending_grants.push_back(run_clock_policy(cur_beat));
        send = 1'b0;
        beats_in++;
        if (beats_in % 97 == 0) src_mode = $urandom_range(0, 2);
        src_gap = draw_gap(src_mode);
      end
      if (!send) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].drain && pending_grants.size() != 0)) begin
          cur_beat = cmd_backlog.pop_front();
          send = 1'b1;
          in_ch.command     <= cur_beat.command;
          in_ch.process_id  <= cur_beat.pid;
          in_ch.page_number <= cur_beat.page;
          in_ch.touch_frame <= cur_beat.tf;
        end
      end
      in_ch.valid <= send;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_grants.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual frame 0x%0h", $time,
                   out_ch.frame_index);
          errors++;
        end else begin
          grant_t g;
          g = pending_grants.pop_front();
          check_field("frame_index", 32'(g.frame_index), 32'(out_ch.frame_index));
          check_field("page_fault", 32'(g.page_fault), 32'(out_ch.page_fault));
          check_field("evicted_owner", 32'(g.evicted_owner), 32'(out_ch.evicted_owner));
          check_field("evicted_page", 32'(g.evicted_page), 32'(out_ch.evicted_page));
        end
        beats_out++;
        if (beats_out % 64 == 0) snk_mode = $urandom_range(0, 2);
        snk_stall = draw_gap(snk_mode);
      end else if (snk_stall > 0) begin
        snk_stall--;
      end
      out_ch.ready <= (snk_stall == 0);
    end
  end

  initial begin
    int n;
    int r;
    int start;
    int made;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_ALLOC;
    in_ch.process_id  = '0;
    in_ch.page_number = '0;
    in_ch.touch_frame = '0;
    out_ch.ready      = 1'b0;
    errors    = 0;
    beats_in  = 0;
    beats_out = 0;
    src_gap   = 0;
    snk_stall = 0;
    src_mode  = 1;
    snk_mode  = 1;
    hand_pos  = 0;
    for (int f = 0; f < NFRAMES; f++) begin
      resident[f] = 1'b0;
      owner_of[f] = '0;
      page_of[f]  = '0;
      ref_set[f]  = 1'b0;
    end

    // touches of free frames are ignored
    push_touch('0);
    push_touch(FRAME_W'(NFRAMES - 1));
    // fill every frame lowest-first, field extremes at both ends
    push_alloc('0, '0);
    push_alloc('1, '1);
    for (int i = 2; i < NFRAMES; i++)
      push_alloc(OWNER_W'(i), PAGE_W'(12'h800 >> (i - 2)));
    // all reference bits set: full sweep, victim at the hand start
    push_alloc(4'h5, 12'hA5A);
    push_touch(4'h1);
    push_touch(FRAME_W'(NFRAMES - 1));
    push_alloc(4'hA, 12'h5A5, 1'b1);
    push_touch(4'h3);
    push_alloc(4'h3, 12'h001);
    push_alloc(4'hC, 12'hFFE);

    made = 0;
    while (made < RANDOM_CMDS) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        n = $urandom_range(1, 8);
        repeat (n) push_touch(FRAME_W'($urandom_range(0, 15)));
        push_alloc(OWNER_W'($urandom_range(0, 15)), PAGE_W'($urandom_range(0, 4095)));
        made += n + 1;
      end else if (r < 4) begin
        // every bit set again forces a full lap
        start = $urandom_range(0, NFRAMES - 1);
        for (int i = 0; i < NFRAMES; i++)
          push_touch(FRAME_W'((start + i) % NFRAMES));
        push_alloc(OWNER_W'($urandom_range(0, 15)), PAGE_W'($urandom_range(0, 4095)),
                   $urandom_range(0, 7) == 0);
        made += NFRAMES + 1;
      end else if (r < 8) begin
        push_alloc(OWNER_W'($urandom_range(0, 15)), PAGE_W'($urandom_range(0, 4095)),
                   $urandom_range(0, 99) == 0);
        made++;
      end else begin
        push_touch(FRAME_W'($urandom_range(0, 15)));
        made++;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || in_ch.valid || pending_grants.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
